FILE: hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
package deq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_DISPLAY    = 3'd4;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic       wr_front;
		logic       wr_back;
		logic       rd_front;
		logic       rd_back;
		logic       rd_dsp_first;
		logic       rd_dsp_next;
		logic       ld_imm;
		logic       ld_mem;
		logic [1:0] imm_status;
		logic       ld_last;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic dsp_last;
		logic out_valid;
	} dp_status_t;

	// (a + b) mod DEPTH for a, b below DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W + 1)'(DEPTH)) begin
			s = s - (IDX_W + 1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/deq_ctrl.sv
`timescale 1ns / 1ps
module deq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2:0]            req_type,
	input  logic                  m_tready,
	input  deq_pkg::dp_status_t   st,
	output deq_pkg::dp_cmd_t      cmd
);
	import deq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_DSP  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_free;
	logic   accept;

	assign out_free = !st.out_valid || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type) inside
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							cmd.ld_imm     = 1'b1;
							cmd.imm_status = st.full ? STS_FULL : STS_OK;
							cmd.wr_front   = !st.full && (req_type == REQ_PUSH_FRONT);
							cmd.wr_back    = !st.full && (req_type == REQ_PUSH_BACK);
						end
						REQ_POP_FRONT, REQ_POP_BACK: begin
							if (st.empty) begin
								cmd.ld_imm     = 1'b1;
								cmd.imm_status = STS_EMPTY;
							end else begin
								cmd.rd_front = (req_type == REQ_POP_FRONT);
								cmd.rd_back  = (req_type == REQ_POP_BACK);
								state_d      = S_POP;
							end
						end
						REQ_DISPLAY: begin
							if (st.empty) begin
								cmd.ld_imm     = 1'b1;
								cmd.imm_status = STS_EMPTY;
							end else begin
								cmd.rd_dsp_first = 1'b1;
								state_d          = S_DSP;
							end
						end
						default: begin
							// drop undefined requests
						end
					endcase
				end
			end
			S_POP: begin
				if (out_free) begin
					cmd.ld_mem  = 1'b1;
					cmd.ld_last = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_DSP: begin
				// hold the read data while the output is stalled
				if (out_free) begin
					cmd.ld_mem  = 1'b1;
					cmd.ld_last = st.dsp_last;
					if (st.dsp_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_dsp_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/deq_dp.sv
`timescale 1ns / 1ps
module deq_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [deq_pkg::VAL_W-1:0] value,
	input  deq_pkg::dp_cmd_t                 cmd,
	output deq_pkg::dp_status_t              st,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic signed [deq_pkg::VAL_W-1:0] item_value,
	output logic [1:0]                       status,
	output logic                             last
);
	import deq_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_q;

	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] dsp_q;

	logic                    out_valid_q;
	logic [1:0]              out_status_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_last_q;

	logic [IDX_W-1:0] front_prev;
	logic [IDX_W-1:0] front_next;
	logic [IDX_W-1:0] back_pos;
	logic [IDX_W-1:0] last_pos;
	logic [IDX_W-1:0] dsp_next;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic             rd_en;
	logic             wr_en;

	assign front_prev = ring_add(front_q, IDX_W'(DEPTH - 1));
	assign front_next = ring_add(front_q, IDX_W'(1));
	assign back_pos   = ring_add(front_q, IDX_W'(count_q));
	assign last_pos   = ring_add(front_q, IDX_W'(count_q - CNT_W'(1)));
	assign dsp_next   = IDX_W'(dsp_q + 1'b1);

	assign st.empty     = (count_q == '0);
	assign st.full      = (count_q == CNT_W'(DEPTH));
	assign st.dsp_last  = ((CNT_W'(dsp_q) + CNT_W'(1)) == count_q);
	assign st.out_valid = out_valid_q;

	assign wr_en = cmd.wr_front || cmd.wr_back;
	assign waddr = cmd.wr_front ? front_prev : back_pos;

	assign rd_en = cmd.rd_front || cmd.rd_back || cmd.rd_dsp_first || cmd.rd_dsp_next;

	always_comb begin
		raddr = front_q;
		if (cmd.rd_back) begin
			raddr = last_pos;
		end else if (cmd.rd_dsp_next) begin
			raddr = ring_add(front_q, dsp_next);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= value;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			dsp_q   <= '0;
		end else begin
			if (cmd.wr_front) begin
				front_q <= front_prev;
			end else if (cmd.rd_front) begin
				front_q <= front_next;
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.rd_front || cmd.rd_back) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.rd_dsp_first) begin
				dsp_q <= '0;
			end else if (cmd.rd_dsp_next) begin
				dsp_q <= dsp_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_imm || cmd.ld_mem) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_imm) begin
			out_status_q <= cmd.imm_status;
			out_value_q  <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.ld_mem) begin
			out_status_q <= STS_OK;
			out_value_q  <= rdata_q;
			out_last_q   <= cmd.ld_last;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign item_value = out_value_q;
	assign status     = out_status_q;
	assign last       = out_last_q;

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// A push answers from the output register; a pop or a display answers via the registered
// store read, then the output register, and a display emits one result per cycle while
// the output is free. Requests are taken only when idle with the output free; a pop or a
// display holds off new requests until its last result is loaded into the output.
// Reset: arst_n clears front index, count and output valid; store contents stay undefined.
module double_ended_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [2:0]  s_tuser,  // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] item_value
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic        m_tlast   // last
);
	import deq_pkg::*;

	dp_cmd_t           cmd;
	dp_status_t        st;
	logic signed [VAL_W-1:0] item_value;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	deq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      ($signed(s_tdata)),
		.cmd        (cmd),
		.st         (st),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.item_value (item_value),
		.status     (m_tuser),
		.last       (m_tlast)
	);

	assign m_tdata = $unsigned(item_value);

endmodule

FILE: hw/rtl/deq_checker.sv
`timescale 1ns / 1ps
module deq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import deq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast)))
		else $error("stalled result changed");

	// no new request while a result is stuck
	a_no_take_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("request taken while output stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STS_OK) |-> (m_tlast && m_tdata == '0))
		else $error("empty or full result not final or not zero");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STS_OK || m_tuser == STS_EMPTY || m_tuser == STS_FULL))
		else $error("bad status code");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);
